>>> rtl/crdc_pkg.sv
// Shared types and constants for the cartridge ROM dual checksum.
// Holds the accumulator record, variant codes and register indexes.
// No dependencies.
package crdc_pkg;

  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int VARIANT_W = 2;
  localparam logic [4:0] ROT_MASK = 5'h1F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED    = 2'd0,
    REG_VARIANT = 2'd1
  } reg_index_t;

  typedef enum logic [VARIANT_W-1:0] {
    VAR_STANDARD = 2'd0,
    VAR_ADD      = 2'd1,
    VAR_TABLE    = 2'd2,
    VAR_MULTIPLY = 2'd3
  } variant_t;

  typedef struct packed {
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] carry_count;
    logic [WORD_W-1:0] xor_acc;
    logic [WORD_W-1:0] rotate_sum;
    logic [WORD_W-1:0] compare_xor;
    logic [WORD_W-1:0] mix;
  } acc_t;

endpackage

>>> rtl/crdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module crdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/crdc_step.sv
// One-word update of the six checksum accumulators.
// Depends on crdc_pkg for the accumulator record and variant codes.
module crdc_step (
  input  crdc_pkg::acc_t                  acc_cur,
  input  logic [crdc_pkg::WORD_W-1:0]     word,
  input  logic [crdc_pkg::WORD_W-1:0]     table_word,
  input  logic [crdc_pkg::VARIANT_W-1:0]  variant,
  output crdc_pkg::acc_t                  acc_upd
);
  import crdc_pkg::*;

  logic [WORD_W:0]     sum_wide;
  logic [2*WORD_W-1:0] rot_wide;
  logic [WORD_W-1:0]   rot;
  logic [WORD_W-1:0]   rot_sum_new;
  logic [WORD_W-1:0]   mix_term;

  always_comb begin
    sum_wide    = {1'b0, acc_cur.sum} + {1'b0, word};
    rot_wide    = {word, word} << (word[4:0] & ROT_MASK);
    rot         = rot_wide[2*WORD_W-1:WORD_W];
    rot_sum_new = acc_cur.rotate_sum + rot;
    mix_term    = (variant == VAR_TABLE) ? (table_word ^ word) : (rot_sum_new ^ word);

    acc_upd.sum         = sum_wide[WORD_W-1:0];
    acc_upd.carry_count = acc_cur.carry_count + {{(WORD_W-1){1'b0}}, sum_wide[WORD_W]};
    acc_upd.xor_acc     = acc_cur.xor_acc ^ word;
    acc_upd.rotate_sum  = rot_sum_new;
    acc_upd.compare_xor = (acc_cur.compare_xor > word) ? (acc_cur.compare_xor ^ rot)
                        : (acc_cur.compare_xor ^ sum_wide[WORD_W-1:0] ^ word);
    acc_upd.mix         = acc_cur.mix + mix_term;
  end

endmodule

>>> rtl/cartridge_rom_dual_checksum.sv
// Cartridge ROM dual checksum: top level.
// Depends on crdc_pkg, crdc_ram and crdc_step.
//
// Input channel (in_valid/in_stall): one word per accepted beat. kind 0
// writes word_in into boot table slot table_slot and yields nothing; kind 1
// is a checksum data word, and last_word on it closes the run. The first data
// word of a run loads all accumulators from seed_value and restarts the table
// position at zero.
// Output channel (out_valid/out_stall): one word per run carrying
// checksum_high and checksum_low, combined by the variant register.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 seed, 1 variant;
// other indexes are dropped. Write only while idle.
// Throughput: one word per cycle while in_stall is low. The table read is
// issued at acceptance and its registered data meets the word in the input
// register; accumulators update from there, the final values are registered,
// and the combine (including the 32x32 low-half multiply) feeds the output
// register.
// Reset: clears run state, config and all valid flags; table contents stay
// undefined until written. A stalled output holds one run and a second waits
// behind it; other words keep flowing, and in_stall rises when the next last
// word reaches the input register.
module cartridge_rom_dual_checksum #(
  parameter int TABLE_WORDS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [$clog2(TABLE_WORDS)-1:0]    table_slot,
  input  logic [crdc_pkg::WORD_W-1:0]       word_in,
  input  logic                              last_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [crdc_pkg::WORD_W-1:0]       checksum_high,
  output logic [crdc_pkg::WORD_W-1:0]       checksum_low,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crdc_pkg::WORD_W-1:0]       cfg_data
);
  import crdc_pkg::*;

  localparam int POS_W = $clog2(TABLE_WORDS);

  logic [WORD_W-1:0]    seed_value;
  logic [VARIANT_W-1:0] variant;

  logic                 run_started;
  logic [POS_W-1:0]     word_position;
  logic [POS_W-1:0]     rd_pos;
  logic                 accept;
  logic                 accept_data;

  logic                 s2_valid;
  logic                 s2_first;
  logic                 s2_last;
  logic [WORD_W-1:0]    s2_word;
  logic                 s2_go;
  logic [WORD_W-1:0]    table_word;

  acc_t                 acc;
  acc_t                 acc_cur;
  acc_t                 acc_next;
  acc_t                 fv_acc;
  logic                 fv_valid;
  logic                 fv_go;

  logic [WORD_W-1:0]    prod_high;
  logic [WORD_W-1:0]    prod_low;
  logic [WORD_W-1:0]    high_next;
  logic [WORD_W-1:0]    low_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= '0;
      variant    <= VAR_STANDARD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEED:    seed_value <= cfg_data;
        REG_VARIANT: variant    <= cfg_data[VARIANT_W-1:0];
        default:     ;
      endcase
    end
  end

  assign fv_go       = fv_valid && !(out_valid && out_stall);
  assign s2_go       = s2_valid && !(s2_last && fv_valid && !fv_go);
  assign in_stall    = s2_valid && !s2_go;
  assign accept      = in_valid && !in_stall;
  assign accept_data = accept && kind;
  assign rd_pos      = run_started ? word_position : '0;

  // track the table position of each arriving data word
  always_ff @(posedge clk) begin
    if (rst) begin
      run_started   <= 1'b0;
      word_position <= '0;
    end else if (accept_data) begin
      run_started   <= !last_word;
      word_position <= last_word ? '0 : rd_pos + 1'b1;
    end
  end

  crdc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_WORDS)
  ) u_boot_table (
    .clk  (clk),
    .we   (accept && !kind),
    .waddr(table_slot),
    .wdata(word_in),
    .re   (accept_data),
    .raddr(rd_pos),
    .rdata(table_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!in_stall) begin
      s2_valid <= accept_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_data) begin
      s2_first <= !run_started;
      s2_last  <= last_word;
      s2_word  <= word_in;
    end
  end

  always_comb begin
    acc_cur = s2_first ? acc_t'({6{seed_value}}) : acc;
  end

  crdc_step u_step (
    .acc_cur   (acc_cur),
    .word      (s2_word),
    .table_word(table_word),
    .variant   (variant),
    .acc_upd   (acc_next)
  );

  always_ff @(posedge clk) begin
    if (s2_go) begin
      acc <= acc_next;
    end
    if (s2_go && s2_last) begin
      fv_acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv_valid <= 1'b0;
    end else if (s2_go && s2_last) begin
      fv_valid <= 1'b1;
    end else if (fv_go) begin
      fv_valid <= 1'b0;
    end
  end

  always_comb begin
    prod_high = fv_acc.sum * fv_acc.carry_count;
    prod_low  = fv_acc.rotate_sum * fv_acc.compare_xor;
    case (variant)
      VAR_ADD: begin
        high_next = (fv_acc.sum ^ fv_acc.carry_count) + fv_acc.xor_acc;
        low_next  = (fv_acc.rotate_sum ^ fv_acc.compare_xor) + fv_acc.mix;
      end
      VAR_MULTIPLY: begin
        high_next = prod_high + fv_acc.xor_acc;
        low_next  = prod_low + fv_acc.mix;
      end
      default: begin
        high_next = fv_acc.sum ^ fv_acc.carry_count ^ fv_acc.xor_acc;
        low_next  = fv_acc.rotate_sum ^ fv_acc.compare_xor ^ fv_acc.mix;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fv_go) begin
      checksum_high <= high_next;
      checksum_low  <= low_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fv_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s2_valid && s2_last && fv_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_final_holds: assert property (@(posedge clk) disable iff (rst)
    (fv_valid && !fv_go) |=> (fv_valid && $stable(fv_acc)))
    else $error("final accumulator values changed while blocked");

  a_run_start_seeds: assert property (@(posedge clk) disable iff (rst)
    (accept_data && !run_started) |=> (s2_valid && s2_first))
    else $error("first word of a run not marked for seeding");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (accept_data && last_word) |=> (!run_started && word_position == '0))
    else $error("run state not cleared after last word");
`endif

endmodule
